FILE: sv/mrc_pkg.sv
// shared types and constants of the modbus rtu response checker
`timescale 1ns / 1ps

package mrc_pkg;

   // command codes
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_CRC        = 3'd1;
   localparam logic [2:0] ST_EXCEPTION  = 3'd2;
   localparam logic [2:0] ST_UNEXPECTED = 3'd3;
   localparam logic [2:0] ST_SHORT      = 3'd4;
   localparam logic [2:0] ST_OVERFLOW   = 3'd5;

   // function codes that carry data
   localparam logic [7:0] FC_READ_COILS     = 8'h01;
   localparam logic [7:0] FC_READ_DISCRETE  = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
   localparam logic [7:0] FC_READ_INPUT_REG = 8'h04;
   localparam logic [7:0] FC_EXCEPTION_BIT  = 8'h80;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam int MAX_RESULTS = 64;
   localparam int MIN_FRAME   = 4;
   localparam int DATA_START  = 3;

   // one judged frame, handed from front to back
   typedef struct packed {
      logic [2:0] status;
      logic [5:0] items;
      logic       coils;
      logic [2:0] tail;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RD_HI,
      BK_RD_LO,
      BK_EMIT,
      BK_STATUS
   } back_state_type;

endpackage

FILE: sv/mrc_req_if.sv
// request channel: begin commands and response bytes
`timescale 1ns / 1ps

interface mrc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  unit_id;
   logic [7:0]  func_id;
   logic [10:0] item_count;
   logic [7:0]  rx_byte;
   logic        rx_last;

   modport source (
      output valid, cmd, unit_id, func_id, item_count, rx_byte, rx_last,
      input  ready
   );
   modport sink (
      input  valid, cmd, unit_id, func_id, item_count, rx_byte, rx_last,
      output ready
   );
endinterface

FILE: sv/mrc_rsp_if.sv
// response channel: data items and closing status
`timescale 1ns / 1ps

interface mrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] value;
   logic        last;

   modport source (
      output valid, status, value, last,
      input  ready
   );
   modport sink (
      input  valid, status, value, last,
      output ready
   );
endinterface

FILE: sv/mrc_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps

module mrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mrc_job_fifo.sv
// two entry queue of judged frames between front and back
`timescale 1ns / 1ps

module mrc_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mrc_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output mrc_pkg::job_type head,
   output logic             empty
);
   import mrc_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

endmodule

FILE: sv/mrc_front.sv
// front end: takes transactions, stores bytes, runs the crc and judges frames
`timescale 1ns / 1ps

module mrc_front #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   mrc_req_if.sink                        req_chan,
   output logic                           wr_en,
   output logic [$clog2(FRAME_DEPTH)-1:0] wr_addr,
   output logic [7:0]                     wr_data,
   output logic                           push,
   output mrc_pkg::job_type               push_job,
   input  logic                           fifo_full,
   input  logic                           release_store
);
   import mrc_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_DEPTH);
   localparam int LEN_W  = $clog2(FRAME_DEPTH + 1);

   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [15:0]      crc_ff, crc_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       want_slave_ff, want_slave_in;
   logic [7:0]       want_func_ff, want_func_in;
   logic [10:0]      want_count_ff, want_count_in;
   logic [7:0]       b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;
   logic             judge_ff, judge_in;
   logic             lock_ff, lock_in;

   logic             accept;
   logic             has_room;
   logic             coils, regs;
   logic [11:0]      need, items;
   logic             short_data;
   job_type          verdict;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   assign req_chan.ready = !judge_ff && !lock_ff;
   assign accept   = req_chan.valid && req_chan.ready;
   assign has_room = (idx_ff < LEN_W'(FRAME_DEPTH));

   assign wr_en   = accept && (req_chan.cmd == CMD_BYTE) && has_room;
   assign wr_addr = idx_ff[ADDR_W-1:0];
   assign wr_data = req_chan.rx_byte;

   // verdict of the closed frame, from registered state only
   always_comb begin
      coils = (want_func_ff == FC_READ_COILS) || (want_func_ff == FC_READ_DISCRETE);
      regs  = (want_func_ff == FC_READ_HOLDING) || (want_func_ff == FC_READ_INPUT_REG);
      need  = coils ? 12'((13'(want_count_ff) + 13'd7) >> 3) : {want_count_ff, 1'b0};
      items = coils ? need : {1'b0, want_count_ff};
      short_data = ({4'h0, b2_ff} < need) || (13'(idx_ff) < (13'd5 + 13'(need)));

      verdict.status = ST_OK;
      verdict.items  = 6'd0;
      verdict.coils  = coils;
      verdict.tail   = want_count_ff[2:0];
      priority if (ovf_ff) begin
         verdict.status = ST_OVERFLOW;
      end else if (idx_ff < LEN_W'(MIN_FRAME)) begin
         verdict.status = ST_UNEXPECTED;
      end else if (crc_ff != 16'h0000) begin
         verdict.status = ST_CRC;
      end else if (b1_ff == (want_func_ff | FC_EXCEPTION_BIT)) begin
         verdict.status = ST_EXCEPTION;
      end else if ((b0_ff != want_slave_ff) || (b1_ff != want_func_ff)) begin
         verdict.status = ST_UNEXPECTED;
      end else if (!coils && !regs) begin
         verdict.status = ST_OK;
      end else if (short_data) begin
         verdict.status = ST_SHORT;
      end else if (items > 12'(MAX_RESULTS - 1)) begin
         verdict.status = ST_OVERFLOW;
      end else begin
         verdict.items = items[5:0];
      end
   end

   assign push     = judge_ff && !fifo_full;
   assign push_job = verdict;

   always_comb begin
      idx_in        = idx_ff;
      crc_in        = crc_ff;
      ovf_in        = ovf_ff;
      want_slave_in = want_slave_ff;
      want_func_in  = want_func_ff;
      want_count_in = want_count_ff;
      b0_in         = b0_ff;
      b1_in         = b1_ff;
      b2_in         = b2_ff;
      judge_in      = judge_ff;
      lock_in       = lock_ff && !release_store;

      if (accept) begin
         if (req_chan.cmd == CMD_BEGIN) begin
            want_slave_in = req_chan.unit_id;
            want_func_in  = req_chan.func_id;
            want_count_in = req_chan.item_count;
            idx_in        = '0;
            crc_in        = CRC_INIT;
            ovf_in        = 1'b0;
         end else begin
            if (has_room) begin
               idx_in = idx_ff + LEN_W'(1);
               crc_in = crc_feed(crc_ff, req_chan.rx_byte);
               if (idx_ff == LEN_W'(0)) b0_in = req_chan.rx_byte;
               if (idx_ff == LEN_W'(1)) b1_in = req_chan.rx_byte;
               if (idx_ff == LEN_W'(2)) b2_in = req_chan.rx_byte;
            end else begin
               ovf_in = 1'b1;
            end
            judge_in = req_chan.rx_last;
         end
      end

      // frame closes once its verdict is queued
      if (push) begin
         judge_in = 1'b0;
         idx_in   = '0;
         crc_in   = CRC_INIT;
         ovf_in   = 1'b0;
         if ((verdict.status == ST_OK) && (verdict.items != 6'd0)) begin
            lock_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         crc_ff        <= CRC_INIT;
         ovf_ff        <= 1'b0;
         want_slave_ff <= 8'h00;
         want_func_ff  <= 8'h00;
         want_count_ff <= 11'd0;
         judge_ff      <= 1'b0;
         lock_ff       <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         crc_ff        <= crc_in;
         ovf_ff        <= ovf_in;
         want_slave_ff <= want_slave_in;
         want_func_ff  <= want_func_in;
         want_count_ff <= want_count_in;
         judge_ff      <= judge_in;
         lock_ff       <= lock_in;
      end
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      b2_ff <= b2_in;
   end

endmodule

FILE: sv/mrc_back.sv
// back end: reads data items out of the frame store and emits results
`timescale 1ns / 1ps

module mrc_back #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fifo_empty,
   input  mrc_pkg::job_type               head,
   output logic                           pop,
   output logic                           rd_en,
   output logic [$clog2(FRAME_DEPTH)-1:0] rd_addr,
   input  logic [7:0]                     rd_data,
   output logic                           release_store,
   mrc_rsp_if.source                      rsp_chan
);
   import mrc_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [5:0]     left_ff, left_in;
   logic [7:0]     hi_ff, hi_in;

   logic           out_valid_ff, out_valid_in;
   logic [2:0]     out_status_ff, out_status_in;
   logic [15:0]    out_value_ff, out_value_in;
   logic           out_last_ff, out_last_in;

   logic           slot_free;
   logic [7:0]     coil_mask;

   assign slot_free = !out_valid_ff || rsp_chan.ready;
   assign coil_mask = 8'((9'd1 << job_ff.tail) - 9'd1);

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      hi_in         = hi_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;
      release_store = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_empty) begin
               pop     = 1'b1;
               job_in  = head;
               ptr_in  = ADDR_W'(DATA_START);
               left_in = head.items;
               if ((head.status == ST_OK) && (head.items != 6'd0)) begin
                  state_in = BK_RD_HI;
               end else begin
                  state_in = BK_STATUS;
               end
            end
         end
         BK_RD_HI: begin
            rd_en    = 1'b1;
            ptr_in   = ptr_ff + ADDR_W'(1);
            state_in = job_ff.coils ? BK_EMIT : BK_RD_LO;
         end
         BK_RD_LO: begin
            hi_in    = rd_data;
            rd_en    = 1'b1;
            ptr_in   = ptr_ff + ADDR_W'(1);
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_status_in = ST_OK;
               out_last_in   = 1'b0;
               if (job_ff.coils) begin
                  // only the final coil byte can hold bits past the count
                  if ((left_ff == 6'd1) && (job_ff.tail != 3'd0)) begin
                     out_value_in = {8'h00, rd_data & coil_mask};
                  end else begin
                     out_value_in = {8'h00, rd_data};
                  end
               end else begin
                  out_value_in = {hi_ff, rd_data};
               end
               left_in  = left_ff - 6'd1;
               state_in = (left_ff == 6'd1) ? BK_STATUS : BK_RD_HI;
            end
         end
         BK_STATUS: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_status_in = job_ff.status;
               out_value_in  = 16'h0000;
               out_last_in   = 1'b1;
               release_store = (job_ff.status == ST_OK) && (job_ff.items != 6'd0);
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff        <= job_in;
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      hi_ff         <= hi_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.status = out_status_ff;
   assign rsp_chan.value  = out_value_ff;
   assign rsp_chan.last   = out_last_ff;

endmodule

FILE: sv/modbus_rtu_response_checker.sv
// Checks a Modbus RTU response frame and emits its data items and status.
// req_chan carries a begin transaction (expected slave address, function
// code and item count) followed by the response bytes, the final one marked
// with rx_last. Each byte is stored and folded into the CRC-16 in the cycle
// it is taken, so bytes go in at one per cycle while req_chan.ready is high.
// After the last byte the front registers a judge flag, then queues the
// verdict once the queue has room. rsp_chan then gives the data items of a
// good read (registers, or coil bytes with bits past the count cleared) and a
// closing status transaction with last set. The back end reads the frame
// store through one port: BK_RD_HI and BK_EMIT for each coil byte, BK_RD_HI,
// BK_RD_LO and BK_EMIT for each register, BK_STATUS for the status, and
// BK_IDLE takes each verdict off the queue.
// The store is held for a good read with data items until its status has
// been handed to the output register, and new transactions wait for that.
// Status-only verdicts queue in a two-entry buffer instead.
// The output register frees as it is taken, so a stalled receiver holds the
// back end; once the queue fills, req_chan.ready drops. Reset clears the
// expectations, the open frame, the queue and the output; no clearing pass.
`timescale 1ns / 1ps

module modbus_rtu_response_checker #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   mrc_req_if.sink   req_chan,
   mrc_rsp_if.source rsp_chan
);
   import mrc_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              push, pop, fifo_full, fifo_empty;
   job_type           push_job, head;
   logic              release_store;

   mrc_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .push          (push),
      .push_job      (push_job),
      .fifo_full     (fifo_full),
      .release_store (release_store)
   );

   mrc_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (fifo_full),
      .pop      (pop),
      .head     (head),
      .empty    (fifo_empty)
   );

   mrc_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mrc_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_empty    (fifo_empty),
      .head          (head),
      .pop           (pop),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .release_store (release_store),
      .rsp_chan      (rsp_chan)
   );

endmodule

FILE: test/mrc_frame_monitor.sv
// watches both channels, works out each frame's verdict and compares the replies
`timescale 1ns / 1ps

module mrc_frame_monitor #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_unit_id,
   input  logic [7:0]  req_func_id,
   input  logic [10:0] req_item_count,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_rx_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_value,
   input  logic        rsp_last,
   output int          mismatches,
   output int          outstanding
);
   import mrc_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] value;
      logic        last;
   } reply_type;

   reply_type   reply_items[$];
   logic [7:0]  frame_copy[FRAME_DEPTH];
   int          fill;
   logic [15:0] crc_run;
   logic [7:0]  want_slave;
   logic [7:0]  want_func;
   logic [10:0] want_count;
   bit          spilled;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic report(input string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t mismatch: %s", $time, what);
      end
   endtask

   task automatic add_reply(input logic [2:0] status, input logic [15:0] value,
                            input logic last);
      reply_type r;
      r.status = status;
      r.value = value;
      r.last = last;
      reply_items.push_back(r);
   endtask

   task automatic judge_frame;
      bit         coils;
      bit         regs;
      int         need;
      int         count_items;
      int         left;
      logic [7:0] bits8;
      logic [7:0] echo_fc;
      coils = (want_func == FC_READ_COILS) || (want_func == FC_READ_DISCRETE);
      regs = (want_func == FC_READ_HOLDING) || (want_func == FC_READ_INPUT_REG);
      echo_fc = want_func | FC_EXCEPTION_BIT;
      need = coils ? (int'(want_count) + 7) / 8 : 2 * int'(want_count);
      count_items = coils ? need : int'(want_count);
      if (spilled) begin
         add_reply(ST_OVERFLOW, 16'h0000, 1'b1);
      end else if (fill < MIN_FRAME) begin
         add_reply(ST_UNEXPECTED, 16'h0000, 1'b1);
      end else if (crc_run != 16'h0000) begin
         add_reply(ST_CRC, 16'h0000, 1'b1);
      end else if (frame_copy[1] == echo_fc) begin
         add_reply(ST_EXCEPTION, 16'h0000, 1'b1);
      end else if (frame_copy[0] != want_slave || frame_copy[1] != want_func) begin
         add_reply(ST_UNEXPECTED, 16'h0000, 1'b1);
      end else if (!coils && !regs) begin
         add_reply(ST_OK, 16'h0000, 1'b1);
      end else if (int'(frame_copy[2]) < need || fill < DATA_START + 2 + need) begin
         add_reply(ST_SHORT, 16'h0000, 1'b1);
      end else if (count_items > MAX_RESULTS - 1) begin
         add_reply(ST_OVERFLOW, 16'h0000, 1'b1);
      end else begin
         for (int i = 0; i < count_items; i++) begin
            if (coils) begin
               // bits past the requested coil count read as zero
               left = int'(want_count) - 8 * i;
               bits8 = frame_copy[DATA_START + i];
               if (left < 8) begin
                  bits8 = bits8 & ((8'd1 << left) - 8'd1);
               end
               add_reply(ST_OK, {8'h00, bits8}, 1'b0);
            end else begin
               add_reply(ST_OK, {frame_copy[DATA_START + 2 * i],
                                 frame_copy[DATA_START + 1 + 2 * i]}, 1'b0);
            end
         end
         add_reply(ST_OK, 16'h0000, 1'b1);
      end
   endtask

   task automatic take_request;
      if (req_cmd == CMD_BEGIN) begin
         want_slave = req_unit_id;
         want_func = req_func_id;
         want_count = req_item_count;
         fill = 0;
         crc_run = CRC_INIT;
         spilled = 1'b0;
      end else begin
         // a full store drops the byte, it never reaches the crc
         if (fill < FRAME_DEPTH) begin
            frame_copy[fill] = req_rx_byte;
            crc_run = crc_fold(crc_run, req_rx_byte);
            fill++;
         end else begin
            spilled = 1'b1;
         end
         if (req_rx_last) begin
            judge_frame();
            fill = 0;
            crc_run = CRC_INIT;
            spilled = 1'b0;
         end
      end
   endtask

   task automatic check_reply;
      reply_type want;
      if (reply_items.size() == 0) begin
         report($sformatf("status %0d value %h last %b with nothing awaited",
                          rsp_status, rsp_value, rsp_last));
      end else begin
         want = reply_items.pop_front();
         if (rsp_status !== want.status || rsp_value !== want.value ||
             rsp_last !== want.last) begin
            report($sformatf("got status %0d value %h last %b, want %0d %h %b",
                             rsp_status, rsp_value, rsp_last,
                             want.status, want.value, want.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reply_items.delete();
         mismatches = 0;
         fill = 0;
         crc_run = CRC_INIT;
         spilled = 1'b0;
         want_slave = 8'h00;
         want_func = 8'h00;
         want_count = 11'd0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_reply();
         end
         if (req_valid && req_ready) begin
            take_request();
         end
      end
      outstanding = reply_items.size();
   end

endmodule

FILE: test/modbus_rtu_response_checker_tb.sv
// top of the response checker testbench: clock, reset, frame stimulus and verdict
`timescale 1ns / 1ps

module modbus_rtu_response_checker_tb;
   import mrc_pkg::*;

   localparam int FRAME_DEPTH = 64;

   typedef enum int {
      RX_GOOD,
      RX_BAD_CRC,
      RX_EXCEPTION_REPLY,
      RX_WRONG_SLAVE,
      RX_WRONG_FUNC,
      RX_ODD_COUNT,
      RX_TRUNCATED,
      RX_RUNT,
      RX_STRAY,
      RX_BIG_COUNT,
      RX_FULL_STORE,
      RX_OVERRUN
   } reply_shape_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrc_req_if req();
   mrc_rsp_if rsp();

   int         mismatch_count;
   int         awaiting;
   int         sent;
   int         budget;
   int         frame_no;
   bit         steady;
   logic [7:0] frame_bytes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   modbus_rtu_response_checker #(.FRAME_DEPTH(FRAME_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req),
      .rsp_chan(rsp)
   );

   mrc_frame_monitor #(.FRAME_DEPTH(FRAME_DEPTH)) monitor (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .req_cmd(req.cmd),
      .req_unit_id(req.unit_id),
      .req_func_id(req.func_id),
      .req_item_count(req.item_count),
      .req_rx_byte(req.rx_byte),
      .req_rx_last(req.rx_last),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .rsp_status(rsp.status),
      .rsp_value(rsp.value),
      .rsp_last(rsp.last),
      .mismatches(mismatch_count),
      .outstanding(awaiting)
   );

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // holds one transaction on the request channel until it is taken
   task automatic offer(input logic cmd, input logic [7:0] sa, input logic [7:0] fc,
                        input logic [10:0] cnt, input logic [7:0] data, input logic fin);
      while (!steady && $urandom_range(0, 99) < 18) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.unit_id <= sa;
      req.func_id <= fc;
      req.item_count <= cnt;
      req.rx_byte <= data;
      req.rx_last <= fin;
      do @(posedge clock); while (!req.ready);
      sent++;
   endtask

   task automatic send_begin(input logic [7:0] sa, input logic [7:0] fc, input logic [10:0] cnt);
      offer(CMD_BEGIN, sa, fc, cnt, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_byte(input logic [7:0] data, input logic fin);
      offer(CMD_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
            11'($urandom_range(0, 2000)), data, fin);
   endtask

   task automatic send_frame;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   // crc goes out low byte first
   task automatic seal_frame;
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         c = crc16_byte(c, frame_bytes[i]);
      end
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endtask

   task automatic random_exchange(input int nr);
      reply_shape_type shape;
      logic [7:0]   sa;
      logic [7:0]   fc;
      logic [10:0]  cnt;
      bit           is_read;
      int           need;
      int           bc;
      int           pick;
      int           idx;
      sa = 8'($urandom_range(0, 255));
      pick = int'($urandom_range(0, 99));
      if (pick < 35) begin
         fc = 8'($urandom_range(FC_READ_COILS, FC_READ_DISCRETE));
      end else if (pick < 75) begin
         fc = 8'($urandom_range(FC_READ_HOLDING, FC_READ_INPUT_REG));
      end else begin
         fc = 8'($urandom_range(0, 255));
      end
      pick = int'($urandom_range(0, 99));
      if (nr == 1) shape = RX_FULL_STORE;
      else if (nr == 4) shape = RX_OVERRUN;
      else if (pick < 50) shape = RX_GOOD;
      else if (pick < 57) shape = RX_BAD_CRC;
      else if (pick < 63) shape = RX_EXCEPTION_REPLY;
      else if (pick < 68) shape = RX_WRONG_SLAVE;
      else if (pick < 73) shape = RX_WRONG_FUNC;
      else if (pick < 78) shape = RX_ODD_COUNT;
      else if (pick < 83) shape = RX_TRUNCATED;
      else if (pick < 88) shape = RX_RUNT;
      else if (pick < 93) shape = RX_STRAY;
      else shape = RX_BIG_COUNT;
      if (shape == RX_FULL_STORE) begin
         fc = FC_READ_HOLDING;
      end
      is_read = 1'b1;
      if (fc == FC_READ_COILS || fc == FC_READ_DISCRETE) begin
         cnt = 11'($urandom_range(0, 24));
         need = (int'(cnt) + 7) / 8;
      end else if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT_REG) begin
         cnt = 11'($urandom_range(0, 5));
         need = 2 * int'(cnt);
      end else begin
         is_read = 1'b0;
         cnt = 11'($urandom_range(0, 2000));
         need = 0;
      end
      bc = ($urandom_range(0, 3) == 0) ? need + int'($urandom_range(1, 2)) : need;
      if (shape == RX_FULL_STORE) begin
         // 3 + 59 + 2 bytes fill the store exactly
         cnt = 11'd29;
         bc = 59;
      end
      if (shape == RX_BIG_COUNT) begin
         cnt = 11'($urandom_range(0, 2000));
         bc = int'($urandom_range(0, 255));
      end
      frame_bytes.delete();
      unique case (shape)
         RX_STRAY: begin
            if ($urandom_range(0, 1) == 0) begin
               send_begin(sa, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2000)));
            end else begin
               repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
               send_frame();
            end
         end
         RX_RUNT: begin
            send_begin(sa, fc, cnt);
            frame_bytes.push_back(sa);
            repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            send_frame();
         end
         RX_OVERRUN: begin
            send_begin(sa, fc, cnt);
            repeat ($urandom_range(65, 68)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            send_frame();
         end
         RX_EXCEPTION_REPLY: begin
            send_begin(sa, fc, cnt);
            frame_bytes.push_back(sa);
            frame_bytes.push_back(fc | FC_EXCEPTION_BIT);
            frame_bytes.push_back(8'($urandom_range(1, 11)));
            seal_frame();
            send_frame();
         end
         default: begin
            send_begin(sa, fc, cnt);
            frame_bytes.push_back(sa);
            frame_bytes.push_back(fc);
            if (is_read || shape == RX_BIG_COUNT) begin
               if (shape == RX_BIG_COUNT) bc = bc % 7;
               frame_bytes.push_back(8'(bc));
               repeat (bc) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
               // write echo: address and value or quantity
               repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if (shape == RX_WRONG_SLAVE) begin
               frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
            end
            if (shape == RX_WRONG_FUNC) begin
               frame_bytes[1] = frame_bytes[1] ^ 8'($urandom_range(1, 127));
            end
            if (shape == RX_ODD_COUNT) begin
               frame_bytes[2] = 8'($urandom_range(0, 255));
            end
            if (shape == RX_TRUNCATED) begin
               repeat ($urandom_range(1, 3)) begin
                  if (frame_bytes.size() > 2) frame_bytes.pop_back();
               end
            end
            seal_frame();
            if (shape == RX_BAD_CRC) begin
               idx = int'($urandom_range(0, frame_bytes.size() - 1));
               frame_bytes[idx] = frame_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            send_frame();
         end
      endcase
   endtask

   // receiver: random back-pressure, one long hold-off, one stretch always ready
   initial begin
      int cyc;
      cyc = 0;
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (cyc >= 100 && cyc < 400) begin
            rsp.ready <= 1'b0;
         end else if (cyc >= 500 && cyc < 650) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= 18);
         end
         cyc++;
         @(posedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      sent = 0;
      steady = 1'b0;
      req.valid <= 1'b0;
      req.cmd <= CMD_BEGIN;
      req.unit_id <= 8'h00;
      req.func_id <= 8'h00;
      req.item_count <= 11'd0;
      req.rx_byte <= 8'h00;
      req.rx_last <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // bytes before any begin meet the reset expectations: write echo, ok
      frame_bytes.delete();
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h00);
      seal_frame();
      send_frame();

      // register read with both value extremes
      send_begin(8'hFF, FC_READ_HOLDING, 11'd2);
      frame_bytes.delete();
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(FC_READ_HOLDING);
      frame_bytes.push_back(8'h04);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h00);
      seal_frame();
      send_frame();

      // eleven coils: second byte keeps only its low three bits
      send_begin(8'h11, FC_READ_COILS, 11'd11);
      frame_bytes.delete();
      frame_bytes.push_back(8'h11);
      frame_bytes.push_back(FC_READ_COILS);
      frame_bytes.push_back(8'h02);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'hFF);
      seal_frame();
      send_frame();

      // exception reply at the largest count
      send_begin(8'h11, FC_READ_INPUT_REG, 11'd2000);
      frame_bytes.delete();
      frame_bytes.push_back(8'h11);
      frame_bytes.push_back(FC_READ_INPUT_REG | FC_EXCEPTION_BIT);
      frame_bytes.push_back(8'h02);
      seal_frame();
      send_frame();

      // frame of two bytes is too short and is judged unexpected
      frame_bytes.delete();
      frame_bytes.push_back(8'h11);
      frame_bytes.push_back(8'h84);
      send_frame();

      // the full store and overrun frames count toward the total
      budget = 170;
      frame_no = 0;
      while (sent < budget) begin
         steady = (frame_no >= 1 && frame_no < 3);
         random_exchange(frame_no);
         frame_no++;
      end
      steady = 1'b0;
      req.valid <= 1'b0;

      do @(posedge clock); while (awaiting != 0);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/mrc_pkg.sv
sv/mrc_req_if.sv
sv/mrc_rsp_if.sv
sv/mrc_ram.sv
sv/mrc_job_fifo.sv
sv/mrc_front.sv
sv/mrc_back.sv
sv/modbus_rtu_response_checker.sv
test/mrc_frame_monitor.sv
test/modbus_rtu_response_checker_tb.sv
